// ===== hw/rtl/base64_stream_decoder_macros.svh =====
// Assertion macros for the Base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

`ifndef SYNTH
`define B64D_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("b64d assertion failed");
`define B64D_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("b64d assertion failed");
`else
`define B64D_ASSERT(label, clk, rstn, prop)
`define B64D_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/b64d_pkg.sv =====
// Shared types and constants of the Base64 stream decoder.
package b64d_pkg;

    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BAD    = 2'd1;
    localparam logic [1:0] STATUS_LONE   = 2'd2;
    localparam logic [1:0] STATUS_NODATA = 2'd3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       end_mark;
    } b64d_result_t;

    // results produced by one accepted character, first goes out first
    typedef struct packed {
        logic [1:0]   count;
        b64d_result_t first;
        b64d_result_t second;
    } b64d_push_t;

endpackage

// ===== hw/rtl/base64_stream_decoder.sv =====
// Base64 stream decoder: one character per beat in, decoded bytes and status out.
// A result is written into the result queue when its character is accepted and is presented on m_ from there, in order.
// Throughput: one character per cycle; the last character of a text may add a
// status beat, so the 4-entry result queue sets the sustained rate when m_ stalls.
// Input is taken while the queue has room for two results.
// Reset: aresetn synchronous active low; clears decoder state and empties the queue.
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_final
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] status, [15:10] zero
    output logic        m_tuser,   // kind
    output logic        m_tlast    // end_mark
);

    logic                beat;
    logic                sx_valid;
    logic [5:0]          sx_value;
    b64d_push_t          push;
    b64d_result_t        out_res;
    logic [Q_CNT_W-1:0]  q_count;

    assign s_tready = (q_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign beat     = s_tvalid && s_tready;

    b64d_sextet u_sextet (
        .char_code (s_tdata),
        .valid     (sx_valid),
        .value     (sx_value)
    );

    b64d_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat      (beat),
        .char_code (s_tdata),
        .is_final  (s_tlast),
        .sx_valid  (sx_valid),
        .sx_value  (sx_value),
        .push      (push)
    );

    b64d_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_tvalid && m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .count     (q_count)
    );

    assign m_tdata = {6'd0, out_res.status, out_res.data_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.end_mark;

    `B64D_ASSERT(a_queue_bound, aclk, aresetn, q_count <= Q_CNT_W'(Q_DEPTH))
    `B64D_ASSERT_NEXT(a_final_gives_result, aclk, aresetn, beat && s_tlast, m_tvalid)
    `B64D_ASSERT(a_end_is_status, aclk, aresetn, !(m_tvalid && m_tlast) || m_tuser)
    `B64D_ASSERT(a_data_status, aclk, aresetn, !m_tvalid || m_tuser || m_tdata[9:8] == STATUS_OK)

endmodule

// ===== hw/rtl/b64d_sextet.sv =====
// Character to 6-bit value lookup for the standard Base64 alphabet.
module b64d_sextet
    import b64d_pkg::*;
(
    input  logic [7:0] char_code,
    output logic       valid,
    output logic [5:0] value
);

    always_comb begin
        valid = 1'b1;
        value = 6'd0;
        if (char_code >= 8'h41 && char_code <= 8'h5A) begin
            value = 6'(char_code - 8'h41);
        end else if (char_code >= 8'h61 && char_code <= 8'h7A) begin
            value = 6'(char_code - 8'h61 + 8'd26);
        end else if (char_code >= 8'h30 && char_code <= 8'h39) begin
            value = 6'(char_code - 8'h30 + 8'd52);
        end else if (char_code == CH_PLUS) begin
            value = 6'd62;
        end else if (char_code == CH_SLASH) begin
            value = 6'd63;
        end else begin
            valid = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/b64d_core.sv =====
// Group phase, leftover bits and error tracking; builds the results of one beat.
module b64d_core
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       beat,
    input  logic [7:0] char_code,
    input  logic       is_final,
    input  logic       sx_valid,
    input  logic [5:0] sx_value,
    output b64d_push_t push
);

    logic [1:0] phase_reg, phase_next;
    logic [5:0] left_reg, left_next;
    logic       pad_reg, pad_next;
    logic [1:0] err_reg, err_next;
    logic       have_reg, have_next;

    logic       emit;
    logic [7:0] emit_byte;
    logic [1:0] status;
    b64d_result_t data_res, status_res;

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        have_next  = have_reg;
        emit       = 1'b0;
        emit_byte  = 8'd0;
        if (err_reg == STATUS_OK) begin
            if (char_code == CH_PAD) begin
                pad_next = 1'b1;
            end else if (!sx_valid || pad_reg) begin
                err_next = STATUS_BAD;
            end else begin
                have_next = 1'b1;
                case (phase_reg)
                    2'd0: begin
                        left_next  = sx_value;
                        phase_next = 2'd1;
                    end
                    2'd1: begin
                        emit       = 1'b1;
                        emit_byte  = {left_reg, sx_value[5:4]};
                        left_next  = {2'b00, sx_value[3:0]};
                        phase_next = 2'd2;
                    end
                    2'd2: begin
                        emit       = 1'b1;
                        emit_byte  = {left_reg[3:0], sx_value[5:2]};
                        left_next  = {4'b0000, sx_value[1:0]};
                        phase_next = 2'd3;
                    end
                    default: begin
                        emit       = 1'b1;
                        emit_byte  = {left_reg[1:0], sx_value};
                        left_next  = 6'd0;
                        phase_next = 2'd0;
                    end
                endcase
            end
        end

        // end-of-text status looks at the state after this character
        if (err_next != STATUS_OK) begin
            status = err_next;
        end else if (!have_next) begin
            status = STATUS_NODATA;
        end else if (phase_next == 2'd1) begin
            status = STATUS_LONE;
        end else begin
            status = STATUS_OK;
        end

        if (is_final) begin
            phase_next = 2'd0;
            left_next  = 6'd0;
            pad_next   = 1'b0;
            err_next   = STATUS_OK;
            have_next  = 1'b0;
        end
    end

    always_comb begin
        data_res.kind        = KIND_DATA;
        data_res.data_byte   = emit_byte;
        data_res.status      = STATUS_OK;
        data_res.end_mark    = 1'b0;
        status_res.kind      = KIND_STATUS;
        status_res.data_byte = 8'd0;
        status_res.status    = status;
        status_res.end_mark  = 1'b1;

        push.count  = beat ? ({1'b0, emit} + {1'b0, is_final}) : 2'd0;
        push.first  = emit ? data_res : status_res;
        push.second = status_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            left_reg  <= 6'd0;
            pad_reg   <= 1'b0;
            err_reg   <= STATUS_OK;
            have_reg  <= 1'b0;
        end else if (beat) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
            have_reg  <= have_next;
        end
    end

endmodule

// ===== hw/rtl/b64d_fifo.sv =====
// Small result queue; takes up to two results per cycle, hands out one.
module b64d_fifo
    import b64d_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  b64d_push_t          push,
    input  logic                pop,
    output logic                out_valid,
    output b64d_result_t        out_res,
    output logic [Q_CNT_W-1:0]  count
);

    b64d_result_t         mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_reg, wr_next;
    logic [Q_PTR_W-1:0]   rd_reg, rd_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [Q_PTR_W-1:0]   wr_second;

    assign wr_second = wr_reg + Q_PTR_W'(1);
    assign out_valid = (cnt_reg != '0);
    assign out_res   = mem[rd_reg];
    assign count     = cnt_reg;

    always_comb begin
        wr_next  = wr_reg + Q_PTR_W'(push.count);
        rd_next  = rd_reg + Q_PTR_W'(pop);
        cnt_next = cnt_reg + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_second] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== bench/tb_base64_stream_decoder.sv =====
// Self-checking testbench for the Base64 stream decoder: directed texts, random texts, back-pressure.
`timescale 1ns / 1ps

module tb_base64_stream_decoder;
    import b64d_pkg::*;

    localparam int RANDOM_ITEMS = 570;
    localparam int STALL_LIMIT  = 1000;   // cycles with no beat on either side

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] char_code
    logic        s_tlast  = 1'b0;     // is_final
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [7:0] data_byte, [9:8] status, [15:10] zero
    logic        m_tuser;             // kind
    logic        m_tlast;             // end_mark

    // decoder state as predicted from the accepted characters
    logic [1:0]  dec_phase;
    logic [5:0]  dec_leftover;
    logic        dec_padded;
    logic [1:0]  dec_error;
    logic        dec_has_data;

    b64d_result_t predicted_beats[$];
    logic [7:0]   text_chars[$];

    int  mismatch_count = 0;
    int  stall_cycles   = 0;
    int  rx_hold_cycles = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;

    base64_stream_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // {in alphabet, 6-bit value}
    function automatic logic [6:0] sextet_lookup(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return {1'b1, 6'(ch - "A")};
        if (ch >= "a" && ch <= "z") return {1'b1, 6'(ch - "a" + 8'd26)};
        if (ch >= "0" && ch <= "9") return {1'b1, 6'(ch - "0" + 8'd52)};
        if (ch == CH_PLUS)          return {1'b1, 6'd62};
        if (ch == CH_SLASH)         return {1'b1, 6'd63};
        return 7'd0;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26) return "A" + 8'(v);
        if (v < 6'd52) return "a" + 8'(v - 6'd26);
        if (v < 6'd62) return "0" + 8'(v - 6'd52);
        if (v == 6'd62) return CH_PLUS;
        return CH_SLASH;
    endfunction

    function automatic void clear_decoder();
        dec_phase    = 2'd0;
        dec_leftover = 6'd0;
        dec_padded   = 1'b0;
        dec_error    = STATUS_OK;
        dec_has_data = 1'b0;
    endfunction

    // Advance the predicted decoder by one accepted character and queue its results.
    function automatic void decode_char(input logic [7:0] ch, input logic last);
        logic [6:0]   lk;
        b64d_result_t r;
        lk = sextet_lookup(ch);
        r  = '0;
        r.kind   = KIND_DATA;
        r.status = STATUS_OK;
        if (dec_error == STATUS_OK) begin
            if (ch == CH_PAD) begin
                dec_padded = 1'b1;
            end else if (!lk[6] || dec_padded) begin
                dec_error = STATUS_BAD;
            end else begin
                dec_has_data = 1'b1;
                case (dec_phase)
                    2'd0: begin
                        dec_leftover = lk[5:0];
                    end
                    2'd1: begin
                        r.data_byte = {dec_leftover, lk[5:4]};
                        predicted_beats.push_back(r);
                        dec_leftover = {2'b00, lk[3:0]};
                    end
                    2'd2: begin
                        r.data_byte = {dec_leftover[3:0], lk[5:2]};
                        predicted_beats.push_back(r);
                        dec_leftover = {4'b0000, lk[1:0]};
                    end
                    default: begin
                        r.data_byte = {dec_leftover[1:0], lk[5:0]};
                        predicted_beats.push_back(r);
                        dec_leftover = 6'd0;
                    end
                endcase
                dec_phase = dec_phase + 2'd1;
            end
        end
        if (last) begin
            r = '0;
            r.kind     = KIND_STATUS;
            r.end_mark = 1'b1;
            if (dec_error != STATUS_OK)  r.status = dec_error;
            else if (!dec_has_data)      r.status = STATUS_NODATA;
            else if (dec_phase == 2'd1)  r.status = STATUS_LONE;
            else                         r.status = STATUS_OK;
            predicted_beats.push_back(r);
            clear_decoder();
        end
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        decode_char(ch, last);
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_chars.size(); i++)
            send_char(text_chars[i], i == text_chars.size() - 1);
        text_chars.delete();
    endtask

    // Random sextets in the length of a valid encoding of nbytes, optionally padded,
    // with extra '=' after that.
    task automatic add_encoded(input int nbytes, input bit pad, input int extra_pad);
        int rem;
        rem = nbytes % 3;
        repeat ((nbytes / 3) * 4) text_chars.push_back(sextet_char(6'($urandom_range(0, 63))));
        if (rem != 0) begin
            repeat (rem + 1) text_chars.push_back(sextet_char(6'($urandom_range(0, 63))));
            if (pad) repeat (3 - rem) text_chars.push_back(CH_PAD);
        end
        repeat (extra_pad) text_chars.push_back(CH_PAD);
    endtask

    task automatic test_alphabet_extremes();
        // ends of every alphabet range, spread over two full groups
        text_chars = '{"A", CH_SLASH, CH_PLUS, "9"};
        send_text();
        text_chars = '{"Z", "a", "0", "z", CH_PAD, CH_PAD};
        send_text();
        // '=' as the last character
        text_chars = '{"Q", "Q", CH_PAD};
        send_text();
    endtask

    task automatic test_special_cases();
        text_chars = '{"Q"};                          // lone leftover
        send_text();
        text_chars = '{CH_PAD};                       // padding only
        send_text();
        text_chars = '{"A", 8'h00, "B", "C"};         // bad char, rest swallowed
        send_text();
        text_chars = '{"Q", "Q", CH_PAD, "Q"};        // alphabet after padding
        send_text();
        text_chars = '{8'hFF};                        // last character itself bad
        send_text();
    endtask

    task automatic test_backpressure();
        int k;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = 60;
        add_encoded(30, 1'b1, 0);
        send_text();
        rx_hold_cycles = 40;
        for (k = 0; k < 12; k++) begin
            add_encoded($urandom_range(1, 5), 1'b1, 0);
            send_text();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_texts();
        int data_items;
        int pick;
        int pos;
        data_items = 0;
        while (data_items < RANDOM_ITEMS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                if ($urandom_range(0, 15) == 0) add_encoded($urandom_range(13, 48), 1'b1, 0);
                else add_encoded($urandom_range(0, 12), 1'($urandom_range(0, 1)),
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                if (text_chars.size() == 0) text_chars.push_back(CH_PAD);
            end else if (pick == 6) begin
                repeat ($urandom_range(1, 9))
                    text_chars.push_back(sextet_char(6'($urandom_range(0, 63))));
            end else if (pick == 7) begin
                repeat ($urandom_range(1, 8)) text_chars.push_back(8'($urandom_range(0, 255)));
            end else if (pick == 8) begin
                add_encoded($urandom_range(1, 12), 1'b1, 0);
                pos = $urandom_range(0, text_chars.size() - 1);
                text_chars[pos] = 8'($urandom_range(0, 255));
            end else begin
                add_encoded($urandom_range(1, 6), 1'b1, 1);
                repeat ($urandom_range(1, 3))
                    text_chars.push_back(sextet_char(6'($urandom_range(0, 63))));
            end
            data_items += text_chars.size();
            send_text();
        end
    endtask

    // result sink: random stalls, plus a long hold-off when a test asks for one
    initial begin : result_sink
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                repeat (rx_hold_cycles) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
                rx_hold_cycles = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, 8) : 0;
            repeat (gap) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        b64d_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                want = predicted_beats.pop_front();
                check_field("kind",      8'(want.kind),     8'(m_tuser));
                check_field("data_byte", want.data_byte,    m_tdata[7:0]);
                check_field("status",    8'(want.status),   8'(m_tdata[9:8]));
                check_field("end_mark",  8'(want.end_mark), 8'(m_tlast));
                check_field("tdata pad", 8'h00,             8'(m_tdata[15:10]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, predicted_beats.size());
                $display("tb_base64_stream_decoder: done, errors");
                $finish;
            end
        end
    end

    initial begin
        clear_decoder();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_alphabet_extremes();
        test_special_cases();
        test_backpressure();
        test_random_texts();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (predicted_beats.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_base64_stream_decoder: done, clean");
        end else begin
            $display("tb_base64_stream_decoder: done, errors");
        end
        $finish;
    end

endmodule

// ===== base64_stream_decoder.f =====
+incdir+hw/rtl
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_sextet.sv
hw/rtl/b64d_core.sv
hw/rtl/b64d_fifo.sv
hw/rtl/base64_stream_decoder.sv
bench/tb_base64_stream_decoder.sv
